### hw/rtl/nss_pkg.sv
// ----------------------------------------------------------------------------
// nss_pkg
// Shared widths, constants and handshake types for number_set_statistics.
// ----------------------------------------------------------------------------
`default_nettype none

package nss_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int OUT_WIDTH   = 16;
  localparam int DCNT_WIDTH  = 8;
  localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 1;
  localparam int REV_WIDTH   = 20;
  localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH) + 1;

  localparam logic [OUT_WIDTH-1:0]  CNT_MAX    = '1;
  localparam logic [DCNT_WIDTH-1:0] DCNT_MAX   = '1;
  localparam logic [VALUE_WIDTH-1:0] DECIMAL_BASE = VALUE_WIDTH'(10);

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [VALUE_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [VALUE_WIDTH-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/nss_divider.sv
// ----------------------------------------------------------------------------
// nss_divider
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nss_divider
  import nss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [VALUE_WIDTH-1:0] q_r, q_nxt;
  logic [VALUE_WIDTH:0]   r_r, r_nxt;
  logic [VALUE_WIDTH-1:0] d_r, d_nxt;
  logic [STEP_WIDTH-1:0]  cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [VALUE_WIDTH:0]   r_shift;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    r_shift  = {r_r[VALUE_WIDTH-1:0], q_r[VALUE_WIDTH-1]};
    if (req.start) begin
      q_nxt    = req.dividend;
      r_nxt    = '0;
      d_nxt    = req.divisor;
      cnt_nxt  = STEP_WIDTH'(VALUE_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in next dividend bit, subtract when it fits
      if (r_shift >= {1'b0, d_r}) begin
        r_nxt = r_shift - {1'b0, d_r};
        q_nxt = {q_r[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        r_nxt = r_shift;
        q_nxt = {q_r[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_WIDTH'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = q_r;
  assign rsp.remainder = r_r[VALUE_WIDTH-1:0];

endmodule

`default_nettype wire

### hw/rtl/number_set_statistics.sv
// ----------------------------------------------------------------------------
// number_set_statistics
// Per-set max, min, prime count, palindrome count and most-divisors value.
// ----------------------------------------------------------------------------
// One value is taken at a time. For each value the block walks trial divisors
// d = 1, 2, ... while d*d <= value, each remainder coming from a shared
// bit-serial divider (start, one quotient bit per step, then done);
// the divisor count also decides primality (exactly two divisors). Then it
// peels decimal digits by dividing by ten on the same divider, one divide per
// digit, to build the reversed number. An item therefore takes one divide per
// trial divisor up to floor(sqrt(value)) plus one per decimal digit, none for
// zero. The divider is the bottleneck. A finished result sits in an output
// register, so the next item is accepted while it waits; only a second result
// stalls until the first is transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module number_set_statistics
  import nss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // value[15:0]
  input  wire logic        in_tlast,   // last item of the set
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata   // max_value, min_value, prime_count,
                                       // palindrome_count, most_divisors_value
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_CHK, S_DIV_WAIT, S_PAL_CHK, S_PAL_WAIT, S_UPDATE
  } state_t;

  state_t                 state_r;
  logic [VALUE_WIDTH-1:0] v_r;
  logic                   last_r;
  logic [DIV_WIDTH-1:0]   d_r;          // trial divisor
  logic [DCNT_WIDTH-1:0]  dcnt_r;       // divisors of current value
  logic [VALUE_WIDTH-1:0] t_r;          // value with low digits peeled off
  logic [REV_WIDTH-1:0]   rev_r;        // reversed decimal number
  logic                   pal_r;

  // per-set statistics
  logic [OUT_WIDTH-1:0]   max_r, min_r, primes_r, pals_r, best_r;
  logic [DCNT_WIDTH-1:0]  best_cnt_r;

  logic                   out_valid_r;
  logic [79:0]            out_data_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [2*DIV_WIDTH-1:0] dsq;
  logic                   d_stop;
  logic [DCNT_WIDTH:0]    dcnt_add;
  logic [REV_WIDTH-1:0]   rev_next;
  logic                   is_prime;
  logic [OUT_WIDTH-1:0]   max_n, min_n, primes_n, pals_n, best_n;
  logic [DCNT_WIDTH-1:0]  best_cnt_n;
  logic                   out_stall;

  nss_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign dsq    = d_r * d_r;
  assign d_stop = dsq > (2*DIV_WIDTH)'(v_r);

  // shared divider: trial division or divide by ten
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = v_r;
    div_req.divisor  = VALUE_WIDTH'(d_r);
    if (state_r == S_DIV_CHK && !d_stop) begin
      div_req.start = 1'b1;
    end else if (state_r == S_PAL_CHK && t_r != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = t_r;
      div_req.divisor  = DECIMAL_BASE;
    end
  end

  assign dcnt_add = (dsq == (2*DIV_WIDTH)'(v_r)) ? {1'b0, dcnt_r} + 1'b1
                                                 : {1'b0, dcnt_r} + 2'd2;
  assign rev_next = (rev_r << 3) + (rev_r << 1) + REV_WIDTH'(div_rsp.remainder);

  // statistics with the current value folded in
  always_comb begin
    is_prime   = (dcnt_r == DCNT_WIDTH'(2));
    max_n      = (OUT_WIDTH'(v_r) > max_r) ? OUT_WIDTH'(v_r) : max_r;
    min_n      = (OUT_WIDTH'(v_r) < min_r) ? OUT_WIDTH'(v_r) : min_r;
    primes_n   = (is_prime && primes_r != CNT_MAX) ? primes_r + 1'b1 : primes_r;
    pals_n     = (pal_r && pals_r != CNT_MAX) ? pals_r + 1'b1 : pals_r;
    best_n     = best_r;
    best_cnt_n = best_cnt_r;
    if (dcnt_r > best_cnt_r) begin
      best_cnt_n = dcnt_r;
      best_n     = OUT_WIDTH'(v_r);
    end else if (dcnt_r == best_cnt_r && OUT_WIDTH'(v_r) > best_r) begin
      best_n = OUT_WIDTH'(v_r);
    end
  end

  assign out_stall = out_valid_r && !out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      max_r       <= '0;
      min_r       <= '1;
      primes_r    <= '0;
      pals_r      <= '0;
      best_r      <= '0;
      best_cnt_r  <= '0;
    end else begin
      // a new result being loaded keeps the valid flag set
      if (out_valid_r && out_tready && !(state_r == S_UPDATE && last_r)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            v_r     <= in_tdata[VALUE_WIDTH-1:0];
            last_r  <= in_tlast;
            d_r     <= DIV_WIDTH'(1);
            dcnt_r  <= '0;
            state_r <= S_DIV_CHK;
          end
        end
        S_DIV_CHK: begin
          if (d_stop) begin
            t_r     <= v_r;
            rev_r   <= '0;
            state_r <= S_PAL_CHK;
          end else begin
            state_r <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            if (div_rsp.remainder == '0) begin
              dcnt_r <= dcnt_add[DCNT_WIDTH] ? DCNT_MAX : dcnt_add[DCNT_WIDTH-1:0];
            end
            d_r     <= d_r + 1'b1;
            state_r <= S_DIV_CHK;
          end
        end
        S_PAL_CHK: begin
          if (t_r == '0) begin
            pal_r   <= (rev_r == REV_WIDTH'(v_r));
            state_r <= S_UPDATE;
          end else begin
            state_r <= S_PAL_WAIT;
          end
        end
        S_PAL_WAIT: begin
          if (div_rsp.done) begin
            rev_r   <= rev_next;
            t_r     <= div_rsp.quotient;
            state_r <= S_PAL_CHK;
          end
        end
        S_UPDATE: begin
          if (!(last_r && out_stall)) begin
            state_r <= S_IDLE;
            if (last_r) begin
              // emit the set and start a fresh one
              out_valid_r <= 1'b1;
              out_data_r  <= {best_n, pals_n, primes_n, min_n, max_n};
              max_r       <= '0;
              min_r       <= '1;
              primes_r    <= '0;
              pals_r      <= '0;
              best_r      <= '0;
              best_cnt_r  <= '0;
            end else begin
              max_r      <= max_n;
              min_r      <= min_n;
              primes_r   <= primes_n;
              pals_r     <= pals_n;
              best_r     <= best_n;
              best_cnt_r <= best_cnt_n;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // divider only reports in the wait states
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV_WAIT || state_r == S_PAL_WAIT))
    else $error("divider finished outside a wait state");

  // no new divide while one is running
  a_div_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> !div_req.start)
    else $error("divider restarted while busy");

  // trial divisor never passes the square root bound
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_WAIT) |-> (dsq <= (2*DIV_WIDTH)'(v_r)))
    else $error("trial divisor beyond square root");

  // a held result is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_stall |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result lost");

endmodule

`default_nettype wire
